### hdl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, codes and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  // Default width of the microsecond tick counter.
  localparam int OWM_COUNT_WIDTH = 10;

  // Fixed bus timing in ticks.
  localparam logic [9:0] RST_RELEASE_TICKS = 10'd15;
  localparam logic [9:0] WR_ONE_RELEASE    = 10'd58;
  localparam logic [9:0] WR_ZERO_RELEASE   = 10'd2;

  // Register values after reset.
  localparam logic [9:0] RESET_LOW_TICKS_RST    = 10'd750;
  localparam logic [7:0] PRESENCE_WAIT_MAX_RST  = 8'd100;
  localparam logic [7:0] PRESENCE_LOW_MAX_RST   = 8'd240;
  localparam logic [3:0] WRITE_ONE_LOW_RST      = 4'd8;
  localparam logic [6:0] WRITE_ZERO_LOW_RST     = 7'd70;
  localparam logic [3:0] READ_LOW_TICKS_RST     = 4'd10;
  localparam logic [6:0] READ_RECOVER_TICKS_RST = 7'd45;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW_TICKS    = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT_MAX  = 3'd1;
  localparam logic [2:0] REG_PRESENCE_LOW_MAX   = 3'd2;
  localparam logic [2:0] REG_WRITE_ONE_LOW      = 3'd3;
  localparam logic [2:0] REG_WRITE_ZERO_LOW     = 3'd4;
  localparam logic [2:0] REG_READ_LOW_TICKS     = 3'd5;
  localparam logic [2:0] REG_READ_RECOVER_TICKS = 3'd6;

  // Request kinds and command codes.
  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_START = 1'b1;
  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_REL    = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_SAMPLE = 4'd8,
    PH_RD_REC    = 4'd9
  } owm_phase_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] command_code;
    logic [7:0] byte_to_send;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] byte_received;
    logic       presence_fail;
  } owm_out_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] presence_wait_max;
    logic [7:0] presence_low_max;
    logic [3:0] write_one_low;
    logic [6:0] write_zero_low;
    logic [3:0] read_low_ticks;
    logic [6:0] read_recover_ticks;
  } owm_cfg_t;

  // Sequencer state apart from the tick counter, whose width is a parameter.
  typedef struct packed {
    owm_phase_t phase;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic       presence_flag;
    logic [7:0] last_read;
  } owm_state_t;

endpackage

### hdl/owm_step.sv
// ----------------------------------------------------------------------------
// owm_step
// Next-state and result logic of the bus sequencer for one word.
// ----------------------------------------------------------------------------
module owm_step #(
  parameter int COUNT_WIDTH = owm_pkg::OWM_COUNT_WIDTH
) (
  input  owm_pkg::owm_cfg_t   cfg,
  input  owm_pkg::owm_state_t st,
  input  logic [COUNT_WIDTH-1:0] tick_count,
  input  owm_pkg::owm_in_t    item,
  output owm_pkg::owm_state_t st_next,
  output logic [COUNT_WIDTH-1:0] tick_count_next,
  output owm_pkg::owm_out_t   result
);
  import owm_pkg::*;

  localparam int LW = (COUNT_WIDTH > 10) ? COUNT_WIDTH : 10;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [9:0]             limit;
  logic                   reached;
  logic                   cur_bit;
  logic                   done;

  assign cur_bit = st.shift_byte[0];
  assign cnt_inc = (tick_count == CNT_MAX) ? tick_count : tick_count + COUNT_WIDTH'(1);

  // A limit beyond the counter range acts as the counter maximum.
  assign reached = (cnt_inc == CNT_MAX) || (LW'(cnt_inc) >= LW'(limit));

  always_comb begin
    unique case (st.phase)
      PH_RST_LOW:   limit = cfg.reset_low_ticks;
      PH_RST_REL:   limit = RST_RELEASE_TICKS;
      PH_PRES_WAIT: limit = 10'(cfg.presence_wait_max);
      PH_PRES_LOW:  limit = 10'(cfg.presence_low_max);
      PH_WR_LOW:    limit = cur_bit ? 10'(cfg.write_one_low) : 10'(cfg.write_zero_low);
      PH_WR_REL:    limit = cur_bit ? WR_ONE_RELEASE : WR_ZERO_RELEASE;
      PH_RD_LOW:    limit = 10'(cfg.read_low_ticks);
      PH_RD_REC:    limit = 10'(cfg.read_recover_ticks);
      default:      limit = '0;
    endcase
  end

  always_comb begin
    st_next         = st;
    tick_count_next = tick_count;
    done            = 1'b0;
    if (item.req_type == REQ_START) begin
      if (st.phase == PH_IDLE) begin
        unique case (item.command_code)
          CMD_RESET: begin
            st_next.bit_index = '0;
            st_next.phase     = PH_RST_LOW;
            tick_count_next   = '0;
          end
          CMD_WRITE: begin
            st_next.bit_index  = '0;
            st_next.shift_byte = item.byte_to_send;
            st_next.phase      = PH_WR_LOW;
            tick_count_next    = '0;
          end
          CMD_READ: begin
            st_next.bit_index  = '0;
            st_next.shift_byte = '0;
            st_next.phase      = PH_RD_LOW;
            tick_count_next    = '0;
          end
          default: begin
          end
        endcase
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: begin
        end
        PH_RST_LOW: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) st_next.phase = PH_RST_REL;
        end
        PH_RST_REL: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) st_next.phase = PH_PRES_WAIT;
        end
        PH_PRES_WAIT: begin
          if (!item.line_level) begin
            st_next.phase   = PH_PRES_LOW;
            tick_count_next = '0;
          end else if (reached) begin
            st_next.presence_flag = 1'b1;
            st_next.phase         = PH_IDLE;
            tick_count_next       = '0;
            done                  = 1'b1;
          end else begin
            tick_count_next = cnt_inc;
          end
        end
        PH_PRES_LOW: begin
          if (item.line_level) begin
            st_next.presence_flag = 1'b0;
            st_next.phase         = PH_IDLE;
            tick_count_next       = '0;
            done                  = 1'b1;
          end else if (reached) begin
            st_next.presence_flag = 1'b1;
            st_next.phase         = PH_IDLE;
            tick_count_next       = '0;
            done                  = 1'b1;
          end else begin
            tick_count_next = cnt_inc;
          end
        end
        PH_WR_LOW: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) st_next.phase = PH_WR_REL;
        end
        PH_WR_REL: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) begin
            st_next.shift_byte = {1'b0, st.shift_byte[7:1]};
            if (st.bit_index == 3'd7) begin
              st_next.bit_index = '0;
              st_next.phase     = PH_IDLE;
              done              = 1'b1;
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
              st_next.phase     = PH_WR_LOW;
            end
          end
        end
        PH_RD_LOW: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) st_next.phase = PH_RD_SAMPLE;
        end
        PH_RD_SAMPLE: begin
          st_next.shift_byte[st.bit_index] = st.shift_byte[st.bit_index] | item.line_level;
          st_next.phase   = PH_RD_REC;
          tick_count_next = '0;
        end
        PH_RD_REC: begin
          tick_count_next = reached ? '0 : cnt_inc;
          if (reached) begin
            if (st.bit_index == 3'd7) begin
              st_next.last_read = st.shift_byte;
              st_next.bit_index = '0;
              st_next.phase     = PH_IDLE;
              done              = 1'b1;
            end else begin
              st_next.bit_index = st.bit_index + 3'd1;
              st_next.phase     = PH_RD_LOW;
            end
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.drive_low     = (st_next.phase == PH_RST_LOW) || (st_next.phase == PH_WR_LOW) ||
                           (st_next.phase == PH_RD_LOW);
    result.busy_res      = (st_next.phase != PH_IDLE);
    result.done_res      = done;
    result.byte_received = st_next.last_read;
    result.presence_fail = st_next.presence_flag;
  end

endmodule

### hdl/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// One-wire bus master sequencer stepped by microsecond tick words.
// ----------------------------------------------------------------------------
// Each input word is either a start command or one microsecond tick that
// carries the sampled bus level. The block takes one word per clock and
// returns exactly one result word for it the next cycle; the whole update
// of the sequencer state is a single pass of logic from the state registers
// to the output register. A new word is taken whenever the output register
// is empty or being read in the same cycle, so with the output side always
// ready the block runs at one word per clock indefinitely. The result shows
// the state after the word: whether the master pulls the line low, whether
// an operation is running, whether one just finished, the last byte read
// and the presence failure flag of the last bus reset. Configuration writes
// are taken in any cycle and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module onewire_bus_master #(
  parameter int COUNT_WIDTH = owm_pkg::OWM_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  owm_pkg::owm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output owm_pkg::owm_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [9:0]        cfg_data
);
  import owm_pkg::*;

  owm_cfg_t               cfg;
  owm_state_t             st;
  owm_state_t             st_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  owm_out_t               result;
  logic                   in_accept;

  // The output register is the only thing that can hold the input side back.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Timing registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks    <= RESET_LOW_TICKS_RST;
      cfg.presence_wait_max  <= PRESENCE_WAIT_MAX_RST;
      cfg.presence_low_max   <= PRESENCE_LOW_MAX_RST;
      cfg.write_one_low      <= WRITE_ONE_LOW_RST;
      cfg.write_zero_low     <= WRITE_ZERO_LOW_RST;
      cfg.read_low_ticks     <= READ_LOW_TICKS_RST;
      cfg.read_recover_ticks <= READ_RECOVER_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESET_LOW_TICKS:    cfg.reset_low_ticks    <= cfg_data;
        REG_PRESENCE_WAIT_MAX:  cfg.presence_wait_max  <= cfg_data[7:0];
        REG_PRESENCE_LOW_MAX:   cfg.presence_low_max   <= cfg_data[7:0];
        REG_WRITE_ONE_LOW:      cfg.write_one_low      <= cfg_data[3:0];
        REG_WRITE_ZERO_LOW:     cfg.write_zero_low     <= cfg_data[6:0];
        REG_READ_LOW_TICKS:     cfg.read_low_ticks     <= cfg_data[3:0];
        REG_READ_RECOVER_TICKS: cfg.read_recover_ticks <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  owm_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg            (cfg),
    .st             (st),
    .tick_count     (tick_count),
    .item           (in_data),
    .st_next        (st_next),
    .tick_count_next(tick_count_next),
    .result         (result)
  );

  // Sequencer state advances only on an accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.bit_index     <= '0;
      st.shift_byte    <= '0;
      st.presence_flag <= 1'b0;
      st.last_read     <= '0;
      tick_count       <= '0;
    end else if (in_accept) begin
      st         <= st_next;
      tick_count <= tick_count_next;
    end
  end

  // Output register: loaded on every accepted word, emptied when read.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-wire bus master. Words carrying start
// commands and microsecond ticks are sent through the input handshake while
// a bus model in the bench tracks the sequencer and predicts every status
// word. Each status word is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
  import owm_pkg::*;

  // Command code that the block must ignore when it arrives in a start word.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Largest value the tick counter can hold before it saturates.
  localparam int unsigned TICK_MAX = (1 << OWM_COUNT_WIDTH) - 1;

  // Words of operation traffic that the random part sends per timing setting.
  localparam int RANDOM_WORDS_PER_SETTING = 60;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  owm_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  owm_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = REG_RESET_LOW_TICKS;
  logic [9:0] cfg_data  = '0;

  // Random idling on both sides is switched off for the last part of the run.
  bit stalls_on = 1'b1;
  int fail_count = 0;
  // Words sent inside operations, used to pace the random part.
  int op_words = 0;

  // Status words predicted for accepted input words, oldest first.
  owm_out_t bus_status_q[$];

  // Bus model: timing registers and sequencer state as the bench sees them.
  owm_cfg_t    tmg;
  owm_phase_t  bus_phase;
  int unsigned slot_ticks;
  logic [2:0]  slot_bit;
  logic [7:0]  slot_shift;
  logic        fail_flag;
  logic [7:0]  rd_byte;

  onewire_bus_master uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is far shorter than this even with every stall at its longest;
  // reaching it means the block stopped taking or returning words.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Bus model
  // ---------------------------------------------------------------------------

  function automatic void reset_bus_model();
    tmg.reset_low_ticks    = RESET_LOW_TICKS_RST;
    tmg.presence_wait_max  = PRESENCE_WAIT_MAX_RST;
    tmg.presence_low_max   = PRESENCE_LOW_MAX_RST;
    tmg.write_one_low      = WRITE_ONE_LOW_RST;
    tmg.write_zero_low     = WRITE_ZERO_LOW_RST;
    tmg.read_low_ticks     = READ_LOW_TICKS_RST;
    tmg.read_recover_ticks = READ_RECOVER_TICKS_RST;
    bus_phase  = PH_IDLE;
    slot_ticks = 0;
    slot_bit   = '0;
    slot_shift = '0;
    fail_flag  = 1'b0;
    rd_byte    = '0;
  endfunction

  function automatic void store_timing(input logic [2:0] idx, input logic [9:0] val);
    case (idx)
      REG_RESET_LOW_TICKS:    tmg.reset_low_ticks    = val[9:0];
      REG_PRESENCE_WAIT_MAX:  tmg.presence_wait_max  = val[7:0];
      REG_PRESENCE_LOW_MAX:   tmg.presence_low_max   = val[7:0];
      REG_WRITE_ONE_LOW:      tmg.write_one_low      = val[3:0];
      REG_WRITE_ZERO_LOW:     tmg.write_zero_low     = val[6:0];
      REG_READ_LOW_TICKS:     tmg.read_low_ticks     = val[3:0];
      REG_READ_RECOVER_TICKS: tmg.read_recover_ticks = val[6:0];
      default: ;
    endcase
  endfunction

  function automatic void enter_phase(input owm_phase_t p);
    bus_phase  = p;
    slot_ticks = 0;
  endfunction

  // One tick of the saturating counter; true once the limit is reached.
  function automatic bit tick_reaches(input int unsigned limit);
    int unsigned lim;
    lim = (limit > TICK_MAX) ? TICK_MAX : limit;
    if (slot_ticks < TICK_MAX) slot_ticks++;
    return slot_ticks >= lim;
  endfunction

  // Applies one input word to the bus model and returns the status after it.
  function automatic owm_out_t advance_bus(input owm_in_t w);
    owm_out_t r;
    logic     lsb;
    logic     fin;
    lsb = slot_shift[0];
    fin = 1'b0;
    if (w.req_type == REQ_START) begin
      // Starts are only taken while idle and only with a known command.
      if (bus_phase == PH_IDLE && w.command_code != CMD_UNUSED) begin
        slot_bit = '0;
        case (w.command_code)
          CMD_RESET: enter_phase(PH_RST_LOW);
          CMD_WRITE: begin
            slot_shift = w.byte_to_send;
            enter_phase(PH_WR_LOW);
          end
          default: begin
            slot_shift = '0;
            enter_phase(PH_RD_LOW);
          end
        endcase
      end
    end else begin
      case (bus_phase)
        PH_RST_LOW:
          if (tick_reaches(tmg.reset_low_ticks)) enter_phase(PH_RST_REL);
        PH_RST_REL:
          if (tick_reaches(RST_RELEASE_TICKS)) enter_phase(PH_PRES_WAIT);
        PH_PRES_WAIT: begin
          if (!w.line_level) begin
            enter_phase(PH_PRES_LOW);
          end else if (tick_reaches(tmg.presence_wait_max)) begin
            fail_flag = 1'b1;
            fin = 1'b1;
            enter_phase(PH_IDLE);
          end
        end
        PH_PRES_LOW: begin
          if (w.line_level) begin
            fail_flag = 1'b0;
            fin = 1'b1;
            enter_phase(PH_IDLE);
          end else if (tick_reaches(tmg.presence_low_max)) begin
            fail_flag = 1'b1;
            fin = 1'b1;
            enter_phase(PH_IDLE);
          end
        end
        PH_WR_LOW:
          if (tick_reaches(lsb ? tmg.write_one_low : tmg.write_zero_low))
            enter_phase(PH_WR_REL);
        PH_WR_REL: begin
          if (tick_reaches(lsb ? WR_ONE_RELEASE : WR_ZERO_RELEASE)) begin
            slot_shift = slot_shift >> 1;
            if (slot_bit == 3'd7) begin
              slot_bit = '0;
              fin = 1'b1;
              enter_phase(PH_IDLE);
            end else begin
              slot_bit++;
              enter_phase(PH_WR_LOW);
            end
          end
        end
        PH_RD_LOW:
          if (tick_reaches(tmg.read_low_ticks)) enter_phase(PH_RD_SAMPLE);
        PH_RD_SAMPLE: begin
          slot_shift = slot_shift | (8'(w.line_level) << slot_bit);
          enter_phase(PH_RD_REC);
        end
        PH_RD_REC: begin
          if (tick_reaches(tmg.read_recover_ticks)) begin
            if (slot_bit == 3'd7) begin
              rd_byte = slot_shift;
              slot_bit = '0;
              fin = 1'b1;
              enter_phase(PH_IDLE);
            end else begin
              slot_bit++;
              enter_phase(PH_RD_LOW);
            end
          end
        end
        default: bus_phase = PH_IDLE;
      endcase
    end
    r.drive_low     = bus_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
    r.busy_res      = bus_phase != PH_IDLE;
    r.done_res      = fin;
    r.byte_received = rd_byte;
    r.presence_fail = fail_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------

  // Sends one word and records its predicted status once it is accepted.
  // Valid is left high on return so that back-to-back words never drop it.
  task automatic send_word(input owm_in_t w);
    if (stalls_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bus_status_q.push_back(advance_bus(w));
  endtask

  // Lets every outstanding status word arrive; the block is idle afterwards
  // because each word yields its status in the cycle after it is taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (bus_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register writes leave valid high so that a burst of writes stays legal;
  // set_timing lowers it after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_timing(idx, val);
  endtask

  task automatic set_timing(input owm_cfg_t t);
    wait_drained();
    write_reg(REG_RESET_LOW_TICKS, 10'(t.reset_low_ticks));
    write_reg(REG_PRESENCE_WAIT_MAX, 10'(t.presence_wait_max));
    write_reg(REG_PRESENCE_LOW_MAX, 10'(t.presence_low_max));
    write_reg(REG_WRITE_ONE_LOW, 10'(t.write_one_low));
    write_reg(REG_WRITE_ZERO_LOW, 10'(t.write_zero_low));
    write_reg(REG_READ_LOW_TICKS, 10'(t.read_low_ticks));
    write_reg(REG_READ_RECOVER_TICKS, 10'(t.read_recover_ticks));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------

  // Words the idle block must ignore: ticks with random content and starts
  // that carry the unused command code.
  task automatic idle_words(input int count);
    owm_in_t w;
    for (int i = 0; i < count; i++) begin
      w.req_type     = $urandom_range(0, 1) ? REQ_START : REQ_TICK;
      w.command_code = (w.req_type == REQ_START) ? CMD_UNUSED : 2'($urandom_range(0, 3));
      w.byte_to_send = 8'($urandom_range(0, 255));
      w.line_level   = 1'($urandom_range(0, 1));
      send_word(w);
    end
  endtask

  // Starts one operation and ticks it to completion. For a bus reset the
  // slave is modeled by pres_hi high ticks before its presence low and by
  // pres_lo low ticks of presence; a negative count is chosen at random,
  // with timeouts now and then. With noisy set, stray start words land in
  // the middle of the operation and must be ignored.
  task automatic run_operation(input logic [1:0] cmd, input logic [7:0] data,
                               input int pres_hi, input int pres_lo, input bit noisy);
    owm_in_t w;
    int      hi;
    int      lo;
    int      n_wait;
    int      n_low;
    hi = pres_hi;
    lo = pres_lo;
    if (hi < 0) begin
      case ($urandom_range(0, 5))
        0:       hi = 0;
        1:       hi = tmg.presence_wait_max + $urandom_range(0, 3);
        default: hi = $urandom_range(0, tmg.presence_wait_max);
      endcase
    end
    if (lo < 0) begin
      case ($urandom_range(0, 5))
        0:       lo = 0;
        1:       lo = tmg.presence_low_max + $urandom_range(0, 3);
        default: lo = $urandom_range(0, tmg.presence_low_max);
      endcase
    end
    w.req_type     = REQ_START;
    w.command_code = cmd;
    w.byte_to_send = data;
    w.line_level   = 1'($urandom_range(0, 1));
    send_word(w);
    op_words++;
    n_wait = 0;
    n_low  = 0;
    while (bus_phase != PH_IDLE) begin
      w.req_type     = REQ_TICK;
      w.command_code = 2'($urandom_range(0, 3));
      w.byte_to_send = 8'($urandom_range(0, 255));
      w.line_level   = 1'($urandom_range(0, 1));
      case (bus_phase)
        PH_PRES_WAIT: begin
          w.line_level = (n_wait < hi);
          n_wait++;
        end
        PH_PRES_LOW: begin
          w.line_level = (n_low >= lo);
          n_low++;
        end
        default: ;
      endcase
      if (noisy && $urandom_range(0, 15) == 0) w.req_type = REQ_START;
      send_word(w);
      op_words++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset: ticks and unknown starts leave the block idle.
  task automatic test_idle_ignore();
    idle_words(6);
  endtask

  // Bus reset under reset-value timing with a good presence pulse.
  task automatic test_reset_presence();
    run_operation(CMD_RESET, 8'h00, 10, 10, 1'b0);
  endtask

  // A byte read under reset-value timing with stray starts while busy.
  task automatic test_byte_transfer();
    run_operation(CMD_READ, 8'hFF, -1, -1, 1'b1);
  endtask

  // Every register at the bottom of its usable range.
  task automatic test_timing_min();
    owm_cfg_t t;
    t = '{10'd480, 8'd15, 8'd60, 4'd1, 7'd60, 4'd1, 7'd1};
    set_timing(t);
    run_operation(CMD_READ, 8'h00, -1, -1, 1'b0);
  endtask

  // A zero limit ends its phase on the first tick.
  task automatic test_timing_zero();
    owm_cfg_t t;
    t = '0;
    set_timing(t);
    run_operation(CMD_RESET, 8'h00, 0, 0, 1'b0);
    run_operation(CMD_RESET, 8'h00, 5, 0, 1'b0);
    run_operation(CMD_RESET, 8'h00, 0, 5, 1'b0);
    run_operation(CMD_WRITE, 8'h81, -1, -1, 1'b0);
    run_operation(CMD_READ, 8'h00, -1, -1, 1'b0);
  endtask

  // Random operations under two short random timings so that many
  // operations fit in the run. The last setting runs without idling.
  task automatic test_random_traffic();
    owm_cfg_t t;
    int       first;
    for (int s = 0; s < 2; s++) begin
      t.reset_low_ticks    = 10'($urandom_range(0, 40));
      t.presence_wait_max  = 8'($urandom_range(0, 30));
      t.presence_low_max   = 8'($urandom_range(0, 30));
      t.write_one_low      = 4'($urandom_range(0, 15));
      t.write_zero_low     = 7'($urandom_range(0, 20));
      t.read_low_ticks     = 4'($urandom_range(0, 15));
      t.read_recover_ticks = 7'($urandom_range(0, 20));
      set_timing(t);
      stalls_on = (s != 1);
      first = op_words;
      while (op_words - first < RANDOM_WORDS_PER_SETTING) begin
        case ($urandom_range(0, 9))
          0:       idle_words($urandom_range(1, 4));
          1, 2, 3: run_operation(CMD_RESET, 8'h00, -1, -1, $urandom_range(0, 3) == 0);
          4, 5, 6: run_operation(CMD_WRITE, 8'($urandom_range(0, 255)), -1, -1,
                                 $urandom_range(0, 3) == 0);
          default: run_operation(CMD_READ, 8'($urandom_range(0, 255)), -1, -1,
                                 $urandom_range(0, 3) == 0);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver stalls in random bursts between runs of readiness; once
  // stalls_on drops it stays ready.
  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (stalls_on) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Every status word taken from the block is matched against the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin : check_status
    owm_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (bus_status_q.size() == 0) begin
        $error("status word arrived with no prediction pending");
        fail_count++;
      end else begin
        want = bus_status_q.pop_front();
        if (out_data.drive_low !== want.drive_low) begin
          $error("drive_low: expected %0d, got %0d", want.drive_low, out_data.drive_low);
          fail_count++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          fail_count++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_data.done_res);
          fail_count++;
        end
        if (out_data.byte_received !== want.byte_received) begin
          $error("byte_received: expected 0x%02h, got 0x%02h",
                 want.byte_received, out_data.byte_received);
          fail_count++;
        end
        if (out_data.presence_fail !== want.presence_fail) begin
          $error("presence_fail: expected %0d, got %0d",
                 want.presence_fail, out_data.presence_fail);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    reset_bus_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_idle_ignore();
    test_reset_presence();
    test_byte_transfer();
    test_timing_min();
    test_timing_zero();
    test_random_traffic();

    // All words are in; wait for the last status words, then a few more
    // cycles in case the block emits something it should not.
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/owm_pkg.sv
hdl/owm_step.sv
hdl/onewire_bus_master.sv
bench/testbench.sv
